// ===== hw/rtl/quad_sonar_scan_and_fusion_defines.svh =====
// assertion macros used by the checker
`ifndef QUAD_SONAR_SCAN_AND_FUSION_DEFINES_SVH
`define QUAD_SONAR_SCAN_AND_FUSION_DEFINES_SVH

// same-cycle implication
`define QSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qsf assertion failed");

// next-cycle implication
`define QSF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qsf assertion failed");

`endif

// ===== hw/rtl/qsf_pkg.sv =====
// types and constants of the sonar scan and zone fusion block
package qsf_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [0:0] REG_MIN_DIFF    = 1'b0;
    localparam logic [0:0] REG_CM_PER_TICK = 1'b1;

    localparam logic [7:0]  MIN_DIFF_RST    = 8'd3;
    localparam logic [15:0] CM_PER_TICK_RST = 16'd1124;

    localparam logic [7:0] NO_OBJECT = 8'd255;

    localparam logic OP_TIMER = 1'b0;
    localparam logic OP_ECHO  = 1'b1;

    localparam logic [1:0] WAIT_BURST  = 2'd0;
    localparam logic [1:0] WAIT_DECAY  = 2'd1;
    localparam logic [1:0] WAIT_LISTEN = 2'd2;

    localparam logic [1:0] LAST_XDCR = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [15:0] capture_count;
    } t_in_item;

    typedef struct packed {
        logic       burst_on;
        logic [1:0] wait_select;
        logic       capture_armed;
        logic [1:0] transducer_select;
        logic       scan_done;
        logic [7:0] zone_ll;
        logic [7:0] zone_lc;
        logic [7:0] zone_cl;
        logic [7:0] zone_cc;
        logic [7:0] zone_cr;
        logic [7:0] zone_rc;
        logic [7:0] zone_rr;
    } t_out_item;

endpackage

// ===== hw/rtl/qsf_in_if.sv =====
// request channel carrying timer and echo events
interface qsf_in_if;
    logic              valid;
    logic              ready;
    qsf_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qsf_out_if.sv =====
// result channel carrying transducer control and fused zones
interface qsf_out_if;
    logic               valid;
    logic               ready;
    qsf_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/quad_sonar_scan_and_fusion.sv =====
// Four-transducer sonar sequencer with seven-zone range fusion. One request is taken
// every clock cycle while the result channel is not stalled; each request yields exactly
// one result, presented through the input register, then the result register. The path
// between them is one 16x16 multiply for the echo distance followed by the saturate,
// three pairwise difference compares and the zone select. A result held by a stalled sink
// does not stop the next request from being taken into an empty input register. The user
// writes configuration on the APB port while no request is in flight; it is not enforced.
module quad_sonar_scan_and_fusion (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qsf_pkg::PADDR_W-1:0]        paddr,
    input  logic [qsf_pkg::PDATA_W-1:0]        pwdata,
    output logic [qsf_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    qsf_in_if.sink                             i_req,
    qsf_out_if.source                          o_rsp
);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_BURST  = 2'd1,
        PH_LISTEN = 2'd2
    } t_phase;

    logic [7:0]  r_min_diff;
    logic [15:0] r_cm_per_tick;

    logic        r_in_valid;
    logic        r_in_op;
    logic [15:0] r_in_count;

    logic        r_out_valid;
    qsf_pkg::t_out_item r_out;
    qsf_pkg::t_out_item n_out;

    logic [3:0][7:0] r_ranges, n_ranges;
    logic [6:0][7:0] r_zones, n_zones;
    logic [1:0]      r_idx, n_idx;
    t_phase          r_phase, n_phase;
    logic            r_echo, n_echo;
    logic            r_armed, n_armed;

    logic        adv;
    logic        fire;
    logic        step;
    logic        done;
    logic [31:0] prod;
    logic [7:0]  cm;
    logic [2:0][7:0] f0, f1, f2;
    logic        wr_en;

    function automatic logic [2:0][7:0] fuse(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] thr);
        logic [8:0] d;
        logic [2:0][7:0] z;
        d = ({1'b0, a} >= {1'b0, b}) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
        if (d < {1'b0, thr}) begin
            z[0] = qsf_pkg::NO_OBJECT;
            z[1] = (a < b) ? a : b;
            z[2] = qsf_pkg::NO_OBJECT;
        end else begin
            z[0] = a;
            z[1] = qsf_pkg::NO_OBJECT;
            z[2] = b;
        end
        return z;
    endfunction

    // apb register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            qsf_pkg::REG_MIN_DIFF:    prdata = {24'd0, r_min_diff};
            qsf_pkg::REG_CM_PER_TICK: prdata = {16'd0, r_cm_per_tick};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_diff    <= qsf_pkg::MIN_DIFF_RST;
            r_cm_per_tick <= qsf_pkg::CM_PER_TICK_RST;
        end else if (wr_en) begin
            case (paddr[2])
                qsf_pkg::REG_MIN_DIFF:    r_min_diff    <= pwdata[7:0];
                qsf_pkg::REG_CM_PER_TICK: r_cm_per_tick <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign adv         = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || adv;
    assign fire        = r_in_valid && adv;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // echo distance
    assign prod = {16'd0, r_in_count} * {16'd0, r_cm_per_tick};
    assign cm   = (|prod[31:24]) ? qsf_pkg::NO_OBJECT : prod[23:16];

    always_comb begin
        n_ranges = r_ranges;
        n_idx    = r_idx;
        n_phase  = r_phase;
        n_echo   = r_echo;
        n_armed  = r_armed;
        n_zones  = r_zones;
        step     = 1'b0;
        done     = 1'b0;
        if (fire) begin
            if (r_in_op == qsf_pkg::OP_TIMER) begin
                case (r_phase)
                    PH_START: begin
                        n_armed = 1'b0;
                        if (!r_echo) begin
                            n_ranges[r_idx] = qsf_pkg::NO_OBJECT;
                            step = 1'b1;
                        end else begin
                            n_echo = 1'b0;
                        end
                        n_phase = PH_BURST;
                    end
                    PH_BURST: begin
                        n_phase = PH_LISTEN;
                    end
                    PH_LISTEN: begin
                        n_armed = 1'b1;
                        n_phase = PH_START;
                    end
                    default: begin
                        n_phase = PH_START;
                    end
                endcase
            end else if (r_armed) begin
                n_ranges[r_idx] = cm;
                n_armed = 1'b0;
                n_echo  = 1'b1;
                step    = 1'b1;
            end
            if (step) begin
                if (r_idx == qsf_pkg::LAST_XDCR) begin
                    n_idx = 2'd0;
                    done  = 1'b1;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
        end
        // left to right order is 1, 3, 2, 0
        f0 = fuse(n_ranges[1], n_ranges[3], r_min_diff);
        f1 = fuse(n_ranges[3], n_ranges[2], r_min_diff);
        f2 = fuse(n_ranges[2], n_ranges[0], r_min_diff);
        if (done) begin
            n_zones[0] = f0[0];
            n_zones[1] = f0[1];
            n_zones[2] = f1[0];
            n_zones[3] = f1[1];
            n_zones[4] = f2[0];
            n_zones[5] = f2[1];
            n_zones[6] = f2[2];
        end
    end

    always_comb begin
        n_out.burst_on          = (n_phase == PH_BURST);
        case (n_phase)
            PH_BURST:  n_out.wait_select = qsf_pkg::WAIT_BURST;
            PH_LISTEN: n_out.wait_select = qsf_pkg::WAIT_DECAY;
            default:   n_out.wait_select = qsf_pkg::WAIT_LISTEN;
        endcase
        n_out.capture_armed     = n_armed;
        n_out.transducer_select = n_idx;
        n_out.scan_done         = done;
        n_out.zone_ll           = n_zones[0];
        n_out.zone_lc           = n_zones[1];
        n_out.zone_cl           = n_zones[2];
        n_out.zone_cc           = n_zones[3];
        n_out.zone_cr           = n_zones[4];
        n_out.zone_rc           = n_zones[5];
        n_out.zone_rr           = n_zones[6];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ranges    <= '0;
            r_zones     <= '0;
            r_idx       <= 2'd0;
            r_phase     <= PH_START;
            r_echo      <= 1'b0;
            r_armed     <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            r_ranges <= n_ranges;
            r_zones  <= n_zones;
            r_idx    <= n_idx;
            r_phase  <= n_phase;
            r_echo   <= n_echo;
            r_armed  <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op    <= i_req.data.opcode;
            r_in_count <= i_req.data.capture_count;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hw/rtl/qsf_checker.sv =====
// port-level checks on the result channel of the sonar block
`include "quad_sonar_scan_and_fusion_defines.svh"

module qsf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input qsf_pkg::t_out_item i_data
);

    `QSF_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_data))
    `QSF_ASSERT_IMP(a_burst, i_clk, i_rst_n, i_valid, i_data.burst_on == (i_data.wait_select == qsf_pkg::WAIT_BURST))
    `QSF_ASSERT_IMP(a_done, i_clk, i_rst_n, i_valid && i_data.scan_done, i_data.transducer_select == 2'd0)
    `QSF_ASSERT_IMP(a_armed, i_clk, i_rst_n, i_valid && i_data.capture_armed, !i_data.burst_on && (i_data.wait_select == qsf_pkg::WAIT_LISTEN))

endmodule

bind quad_sonar_scan_and_fusion qsf_checker u_qsf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_data  (o_rsp.data)
);
